// ===== rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // fixed field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // default table depth
  localparam int unsigned DEPTH_DEFAULT = 64;

  // configuration reset values
  localparam logic [IDX_W-1:0] FIRST_RESET = '0;
  localparam logic [IDX_W-1:0] LAST_RESET  = '1;

  // item operation codes
  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST = 1'b0,
    CFG_LAST  = 1'b1
  } cfg_idx_e;

  // input transaction payload
  typedef struct packed {
    opcode_e            opcode;
    logic [IDX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] location;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic cfg_we;
    logic mem_we;
    logic start;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cont;
    logic hit;
  } dp_status_t;

endpackage

// ===== rtl/stbs_datapath.sv =====
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, segment bounds, probe compare and result register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
  parameter int unsigned DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stbs_pkg::ctrl_cmd_t             cmd_i,
  output stbs_pkg::dp_status_t            status_o,
  input  stbs_pkg::in_item_t              in_data_i,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stbs_pkg::IDX_W-1:0]      cfg_data_i,
  output stbs_pkg::out_item_t             out_data_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = stbs_pkg::IDX_W;
  localparam int unsigned DW    = stbs_pkg::DATA_W;
  localparam bit          ALL_IN = (DEPTH >= (1 << IW));

  // configuration registers
  logic [IW-1:0] first_q, last_q;

  // table memory
  logic signed [DW-1:0] mem_q [DEPTH];
  logic signed [DW-1:0] rdata_q;
  logic                 rd_ok_q;

  // search state: beg in 0..64, end in -1..63
  logic        [IW:0]   beg_q, beg_d;
  logic signed [IW:0]   end_q, end_d;
  logic        [IW-1:0] mid_q, mid_d;
  logic signed [DW-1:0] key_q;
  logic signed [IW+1:0] sum;

  logic signed [DW-1:0] probe;
  logic                 wr_ok;
  logic                 rd_ok;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  // result register
  logic          found_q;
  logic [IW-1:0] location_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= stbs_pkg::FIRST_RESET;
      last_q  <= stbs_pkg::LAST_RESET;
    end else if (cmd_i.cfg_we) begin
      case (stbs_pkg::cfg_idx_e'(cfg_index_i))
        stbs_pkg::CFG_FIRST: first_q <= cfg_data_i;
        stbs_pkg::CFG_LAST:  last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next segment bounds and midpoint
  always_comb begin
    beg_d = beg_q;
    end_d = end_q;
    if (cmd_i.start) begin
      beg_d = {1'b0, first_q};
      end_d = signed'({1'b0, last_q});
    end else if (cmd_i.step) begin
      if (key_q < probe) begin
        end_d = signed'({1'b0, mid_q}) - (IW+1)'(1);
      end else begin
        beg_d = {1'b0, mid_q} + (IW+1)'(1);
      end
    end
    // truncating halve: the sum never drops below -1, which halves to 0
    sum = signed'({1'b0, beg_d}) + {end_d[IW], end_d};
    if (sum[IW+1]) begin
      mid_d = '0;
    end else begin
      mid_d = sum[IW:1];
    end
  end

  always_ff @(posedge clk_i) begin
    beg_q <= beg_d;
    end_q <= end_d;
    mid_q <= mid_d;
    if (cmd_i.start) begin
      key_q <= in_data_i.value;
    end
  end

  // index range checks, entries at or above the depth read as zero
  assign wr_ok   = ALL_IN || (int'(in_data_i.entry_index) < int'(DEPTH));
  assign rd_ok   = ALL_IN || (int'(mid_d) < int'(DEPTH));
  assign wr_addr = AW'(in_data_i.entry_index);
  assign rd_addr = AW'(mid_d);

  // table write and registered read at the next midpoint
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && wr_ok) begin
      mem_q[wr_addr] <= in_data_i.value;
    end
    rdata_q <= mem_q[rd_addr];
    rd_ok_q <= rd_ok;
  end

  // probe compare
  assign probe         = rd_ok_q ? rdata_q : '0;
  assign status_o.hit  = (probe == key_q);
  assign status_o.cont = (signed'({1'b0, beg_q}) <= end_q) && (probe != key_q);

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q    <= status_o.hit;
      location_q <= status_o.hit ? mid_q : '0;
    end
  end

  assign out_data_o.found    = found_q;
  assign out_data_o.location = location_q;

endmodule

// ===== rtl/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table writes, search probes and result hand-off.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  stbs_pkg::opcode_e     in_opcode_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  output stbs_pkg::ctrl_cmd_t   cmd_o,
  input  stbs_pkg::dp_status_t  status_i
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PROBE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   idle;
  logic   out_free;

  assign idle     = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // handshake outputs
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign out_valid_o = out_valid_q;

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.cfg_we   = cfg_valid_i && idle;
    cmd_o.mem_we   = idle && in_valid_i && (in_opcode_i == stbs_pkg::OP_WRITE);
    cmd_o.start    = idle && in_valid_i && (in_opcode_i == stbs_pkg::OP_SEARCH);
    cmd_o.step     = !idle && status_i.cont;
    cmd_o.out_load = !idle && !status_i.cont && out_free;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          // a finished search waits here while the result slot is full;
          // the midpoint holds, so the same probe is re-read each cycle
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of signed words loaded by write transactions.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o | in_data_i  : opcode, entry_index, value
//  out      | out_valid_o/out_stall_i | out_data_o : found, location
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A write transaction is accepted while idle and does not stall the input.
//  A search is accepted and then runs its probes: each probe is one
//  registered table read and one compare, and in_stall_o holds the input
//  until the search result is loaded.
//  Reset clears the segment bounds to 0 and 63 and the control state; the
//  table contents stay undefined until written. While out_stall_i holds a
//  result, the next search finishes its probes and then waits for the slot.
//
module sorted_table_binary_search #(
  parameter int unsigned DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stbs_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output stbs_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stbs_pkg::IDX_W-1:0]      cfg_data_i
);

  stbs_pkg::ctrl_cmd_t  cmd;
  stbs_pkg::dp_status_t status;

  // sequencer
  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // table and search datapath
  stbs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule
